@@ rtl/vector_to_yaw_pitch_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the yaw/pitch core
// Shared property shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TO_YAW_PITCH_CORE_DEFINES_SVH
`define VECTOR_TO_YAW_PITCH_CORE_DEFINES_SVH

// Same-cycle implication.
`define VTYP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VTYP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vtyp_pkg.sv @@
// ----------------------------------------------------------------------------
// vtyp_pkg
// Constants, angle table, sideband types and rounding helper for the core.
// ----------------------------------------------------------------------------
package vtyp_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 24;

  // Datapath carries this many bits above the coordinate width.
  localparam int GUARD_BITS = 20;
  localparam int FRAC_BITS  = 16;

  // Angle accumulator in 1/32768 degree.
  localparam int ANGLE_W   = 25;
  localparam int YAW_W     = 16;
  localparam int PITCH_W   = 15;
  localparam int OUT_W     = 32;

  localparam int GAIN_Q16     = 107922;
  localparam int DEG90_ACC    = 2949120;
  localparam int YAW_LIMIT    = 23039;
  localparam int QUARTER_TURN = 11520;

  localparam int TABLE_LEN = 24;

  // atan(2^-i) in 1/32768 degree.
  localparam int ATAN_TAB [TABLE_LEN] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  typedef enum logic [2:0] {
    YK_CORDIC,
    YK_ZERO,
    YK_NEG_LIMIT,
    YK_NEG_90,
    YK_POS_90
  } yaw_kind_t;

  typedef enum logic [1:0] {
    PK_CORDIC,
    PK_ZERO,
    PK_POS_90,
    PK_NEG_90
  } pitch_kind_t;

  typedef struct packed {
    yaw_kind_t   ykind;
    pitch_kind_t pkind;
    logic        degen;
  } flags_t;

  typedef struct packed {
    logic signed [YAW_W-1:0] yaw;
    pitch_kind_t             pkind;
    logic                    degen;
  } pitch_side_t;

  // Round to 1/128 degree (half up) and clamp symmetrically.
  function automatic logic signed [ANGLE_W-1:0] round_clamp(
    input logic signed [ANGLE_W-1:0] z,
    input int                        lim
  );
    logic signed [ANGLE_W-1:0] half;
    logic signed [ANGLE_W-1:0] r;
    logic signed [ANGLE_W-1:0] lim_s;
    half  = ANGLE_W'(128);
    lim_s = ANGLE_W'(lim);
    r     = (z + half) >>> 8;
    if (r > lim_s) begin
      r = lim_s;
    end else if (r < -lim_s) begin
      r = -lim_s;
    end
    return r;
  endfunction

endpackage

@@ rtl/vector_to_yaw_pitch_core.sv @@
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch_core
// Yaw and pitch angles of the direction from one 3-D point to another.
// ----------------------------------------------------------------------------
// The core takes a pair of Q16.8 points A and B and returns the heading
// yaw = atan2(-dy, -dx) and the elevation pitch = atan(dz / |(dx, dy)|) of
// d = B - A, both in 1/128 degree, with yaw held inside +/-179.99 degrees.
// A new pair is accepted on every clock while the skid entry is empty.
// It passes the difference, pre-rotation, yaw CORDIC row, gain, pitch
// CORDIC row, rounding and output registers, with one CORDIC cell per
// stage in each row. When the two points coincide the angles are zero
// and out_tuser flags the result as degenerate. A straight up or down
// vector gives yaw 0 and pitch +/-90 degrees. The output side has a
// one-entry skid buffer, so in_tready depends only on registered state
// and stays high while the consumer takes every transfer.
// ----------------------------------------------------------------------------
`include "vector_to_yaw_pitch_core_defines.svh"

module vector_to_yaw_pitch_core #(
  parameter int CORDIC_STAGES = vtyp_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = vtyp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // Input channel.
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z, zero padding to whole bytes.
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]        in_tdata,
  // Result channel.
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // yaw [15:0], pitch [30:16], zero pad [31].
  output logic [vtyp_pkg::OUT_W-1:0]                out_tdata,
  // degenerate.
  output logic                                      out_tuser
);
  import vtyp_pkg::*;

  localparam int DXW = COORD_WIDTH + 1;
  localparam int DW  = COORD_WIDTH + GUARD_BITS;
  localparam int YSW = DXW + $bits(flags_t);
  localparam int PSW = $bits(pitch_side_t);

  localparam logic signed [DW-1:0] GainDw = DW'(GAIN_Q16);

  // The whole pipeline moves together; it only holds while the skid entry
  // is occupied.
  logic en;
  logic skid_valid_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // --------------------------------------------------------------------------
  // Front end: differences and pre-rotation.
  // --------------------------------------------------------------------------
  logic                      fr_valid;
  logic signed [DW-1:0]      fr_x, fr_y;
  logic signed [ANGLE_W-1:0] fr_z;
  logic signed [DXW-1:0]     fr_dz;
  flags_t                    fr_flags;

  vtyp_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid && en),
    .from_x   (in_tdata[0*COORD_WIDTH +: COORD_WIDTH]),
    .from_y   (in_tdata[1*COORD_WIDTH +: COORD_WIDTH]),
    .from_z   (in_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
    .to_x     (in_tdata[3*COORD_WIDTH +: COORD_WIDTH]),
    .to_y     (in_tdata[4*COORD_WIDTH +: COORD_WIDTH]),
    .to_z     (in_tdata[5*COORD_WIDTH +: COORD_WIDTH]),
    .out_valid(fr_valid),
    .out_x    (fr_x),
    .out_y    (fr_y),
    .out_z    (fr_z),
    .out_dz   (fr_dz),
    .out_flags(fr_flags)
  );

  // --------------------------------------------------------------------------
  // Yaw row. Its final x is the horizontal length times the CORDIC gain,
  // which feeds the pitch row directly.
  // --------------------------------------------------------------------------
  logic                      yr_valid;
  logic signed [DW-1:0]      yr_x;
  logic signed [ANGLE_W-1:0] yr_z;
  logic [YSW-1:0]            yr_side;
  logic signed [DXW-1:0]     yr_dz;
  flags_t                    yr_flags;

  vtyp_cordic_row #(
    .DW    (DW),
    .SW    (YSW),
    .STAGES(CORDIC_STAGES)
  ) u_yaw_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (fr_valid),
    .in_x     (fr_x),
    .in_y     (fr_y),
    .in_z     (fr_z),
    .in_side  ({fr_dz, fr_flags}),
    .out_valid(yr_valid),
    .out_x    (yr_x),
    .out_y    (),
    .out_z    (yr_z),
    .out_side (yr_side)
  );

  assign yr_dz    = yr_side[YSW-1 -: DXW];
  assign yr_flags = yr_side[$bits(flags_t)-1:0];

  // --------------------------------------------------------------------------
  // Middle stage: final yaw value, and dz scaled by the CORDIC gain so both
  // pitch operands carry the same gain.
  // --------------------------------------------------------------------------
  logic                      mid_valid_r;
  logic signed [DW-1:0]      mid_x_r;
  logic signed [DW-1:0]      mid_y_r, mid_y_nxt;
  pitch_side_t               mid_side_r, mid_side_nxt;
  logic signed [DW-1:0]      dz_ext;
  logic signed [ANGLE_W-1:0] yaw_full;

  always_comb begin
    dz_ext    = DW'(yr_dz);
    mid_y_nxt = dz_ext * GainDw;
    yaw_full  = round_clamp(yr_z, YAW_LIMIT);

    mid_side_nxt.pkind = yr_flags.pkind;
    mid_side_nxt.degen = yr_flags.degen;
    case (yr_flags.ykind)
      YK_CORDIC:    mid_side_nxt.yaw = yaw_full[YAW_W-1:0];
      YK_ZERO:      mid_side_nxt.yaw = '0;
      YK_NEG_LIMIT: mid_side_nxt.yaw = YAW_W'(-YAW_LIMIT);
      YK_NEG_90:    mid_side_nxt.yaw = YAW_W'(-QUARTER_TURN);
      YK_POS_90:    mid_side_nxt.yaw = YAW_W'(QUARTER_TURN);
      default:      mid_side_nxt.yaw = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (en) begin
      mid_valid_r <= yr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_x_r    <= yr_x;
      mid_y_r    <= mid_y_nxt;
      mid_side_r <= mid_side_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Pitch row.
  // --------------------------------------------------------------------------
  logic                      pr_valid;
  logic signed [ANGLE_W-1:0] pr_z;
  logic [PSW-1:0]            pr_side_bits;
  pitch_side_t               pr_side;

  vtyp_cordic_row #(
    .DW    (DW),
    .SW    (PSW),
    .STAGES(CORDIC_STAGES)
  ) u_pitch_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (mid_valid_r),
    .in_x     (mid_x_r),
    .in_y     (mid_y_r),
    .in_z     ('0),
    .in_side  (mid_side_r),
    .out_valid(pr_valid),
    .out_x    (),
    .out_y    (),
    .out_z    (pr_z),
    .out_side (pr_side_bits)
  );

  assign pr_side = pitch_side_t'(pr_side_bits);

  // --------------------------------------------------------------------------
  // Tail stage: final pitch value.
  // --------------------------------------------------------------------------
  logic                      tail_valid_r;
  logic signed [YAW_W-1:0]   tail_yaw_r;
  logic signed [PITCH_W-1:0] tail_pitch_r, tail_pitch_nxt;
  logic                      tail_degen_r;
  logic signed [ANGLE_W-1:0] pitch_full;

  always_comb begin
    pitch_full = round_clamp(pr_z, QUARTER_TURN);
    case (pr_side.pkind)
      PK_CORDIC: tail_pitch_nxt = pitch_full[PITCH_W-1:0];
      PK_ZERO:   tail_pitch_nxt = '0;
      PK_POS_90: tail_pitch_nxt = PITCH_W'(QUARTER_TURN);
      PK_NEG_90: tail_pitch_nxt = PITCH_W'(-QUARTER_TURN);
      default:   tail_pitch_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_valid_r <= 1'b0;
    end else if (en) begin
      tail_valid_r <= pr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_yaw_r   <= pr_side.yaw;
      tail_pitch_r <= tail_pitch_nxt;
      tail_degen_r <= pr_side.degen;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with a one-entry skid buffer. A result leaving the tail
  // goes to the output register when that is free or being drained, and to
  // the skid entry otherwise; the skid entry stalls the pipeline.
  // --------------------------------------------------------------------------
  logic                      push;
  logic                      out_valid_r;
  logic signed [YAW_W-1:0]   out_yaw_r, skid_yaw_r;
  logic signed [PITCH_W-1:0] out_pitch_r, skid_pitch_r;
  logic                      out_degen_r, skid_degen_r;

  assign push = tail_valid_r && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_yaw_r   <= skid_yaw_r;
        out_pitch_r <= skid_pitch_r;
        out_degen_r <= skid_degen_r;
      end else begin
        out_yaw_r   <= tail_yaw_r;
        out_pitch_r <= tail_pitch_r;
        out_degen_r <= tail_degen_r;
      end
    end else if (push) begin
      skid_yaw_r   <= tail_yaw_r;
      skid_pitch_r <= tail_pitch_r;
      skid_degen_r <= tail_degen_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-YAW_W-PITCH_W){1'b0}}, out_pitch_r, out_yaw_r};
  assign out_tuser  = out_degen_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `VTYP_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid entry filled while output register empty")
  `VTYP_ASSERT_NOW(a_degen_zero_angles, out_valid_r && out_degen_r, out_yaw_r == '0 && out_pitch_r == '0, "degenerate result with nonzero angles")
  `VTYP_ASSERT_NOW(a_yaw_range, out_valid_r, out_yaw_r <= YAW_W'(YAW_LIMIT) && out_yaw_r >= YAW_W'(-YAW_LIMIT), "yaw outside its range")
  `VTYP_ASSERT_NOW(a_pitch_range, out_valid_r, out_pitch_r <= PITCH_W'(QUARTER_TURN) && out_pitch_r >= PITCH_W'(-QUARTER_TURN), "pitch outside its range")

endmodule

@@ rtl/vtyp_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// vtyp_cordic_cell
// One vectoring CORDIC micro-rotation with its registers and sideband.
// ----------------------------------------------------------------------------
module vtyp_cordic_cell #(
  parameter int DW    = 44,
  parameter int SW    = 8,
  parameter int STAGE = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [DW-1:0]               in_x,
  input  logic signed [DW-1:0]               in_y,
  input  logic signed [vtyp_pkg::ANGLE_W-1:0] in_z,
  input  logic [SW-1:0]                      in_side,
  output logic                               out_valid,
  output logic signed [DW-1:0]               out_x,
  output logic signed [DW-1:0]               out_y,
  output logic signed [vtyp_pkg::ANGLE_W-1:0] out_z,
  output logic [SW-1:0]                      out_side
);
  import vtyp_pkg::*;

  localparam logic signed [ANGLE_W-1:0] Step = ANGLE_W'(ATAN_TAB[STAGE]);

  logic                      valid_r;
  logic signed [DW-1:0]      x_r, x_nxt;
  logic signed [DW-1:0]      y_r, y_nxt;
  logic signed [ANGLE_W-1:0] z_r, z_nxt;
  logic [SW-1:0]             side_r;
  logic signed [DW-1:0]      xs, ys;

  always_comb begin
    xs = in_x >>> STAGE;
    ys = in_y >>> STAGE;
    // Rotate toward the x axis, direction from the sign of y.
    if (!in_y[DW-1]) begin
      x_nxt = in_x + ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + Step;
    end else begin
      x_nxt = in_x - ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - Step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_side  = side_r;

endmodule

@@ rtl/vtyp_cordic_row.sv @@
// ----------------------------------------------------------------------------
// vtyp_cordic_row
// One CORDIC cell per stage, passing the vector down every cycle en is high.
// ----------------------------------------------------------------------------
module vtyp_cordic_row #(
  parameter int DW     = 44,
  parameter int SW     = 8,
  parameter int STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [DW-1:0]               in_x,
  input  logic signed [DW-1:0]               in_y,
  input  logic signed [vtyp_pkg::ANGLE_W-1:0] in_z,
  input  logic [SW-1:0]                      in_side,
  output logic                               out_valid,
  output logic signed [DW-1:0]               out_x,
  output logic signed [DW-1:0]               out_y,
  output logic signed [vtyp_pkg::ANGLE_W-1:0] out_z,
  output logic [SW-1:0]                      out_side
);
  import vtyp_pkg::*;

  logic                      valid_w [STAGES+1];
  logic signed [DW-1:0]      x_w     [STAGES+1];
  logic signed [DW-1:0]      y_w     [STAGES+1];
  logic signed [ANGLE_W-1:0] z_w     [STAGES+1];
  logic [SW-1:0]             side_w  [STAGES+1];

  assign valid_w[0] = in_valid;
  assign x_w[0]     = in_x;
  assign y_w[0]     = in_y;
  assign z_w[0]     = in_z;
  assign side_w[0]  = in_side;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    vtyp_cordic_cell #(
      .DW   (DW),
      .SW   (SW),
      .STAGE(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (valid_w[i]),
      .in_x     (x_w[i]),
      .in_y     (y_w[i]),
      .in_z     (z_w[i]),
      .in_side  (side_w[i]),
      .out_valid(valid_w[i+1]),
      .out_x    (x_w[i+1]),
      .out_y    (y_w[i+1]),
      .out_z    (z_w[i+1]),
      .out_side (side_w[i+1])
    );
  end

  assign out_valid = valid_w[STAGES];
  assign out_x     = x_w[STAGES];
  assign out_y     = y_w[STAGES];
  assign out_z     = z_w[STAGES];
  assign out_side  = side_w[STAGES];

endmodule

@@ rtl/vtyp_front.sv @@
// ----------------------------------------------------------------------------
// vtyp_front
// Point difference, special-case sorting and quadrant pre-rotation.
// ----------------------------------------------------------------------------
module vtyp_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [COORD_WIDTH-1:0]       from_x,
  input  logic signed [COORD_WIDTH-1:0]       from_y,
  input  logic signed [COORD_WIDTH-1:0]       from_z,
  input  logic signed [COORD_WIDTH-1:0]       to_x,
  input  logic signed [COORD_WIDTH-1:0]       to_y,
  input  logic signed [COORD_WIDTH-1:0]       to_z,
  output logic                                out_valid,
  output logic signed [COORD_WIDTH+vtyp_pkg::GUARD_BITS-1:0] out_x,
  output logic signed [COORD_WIDTH+vtyp_pkg::GUARD_BITS-1:0] out_y,
  output logic signed [vtyp_pkg::ANGLE_W-1:0] out_z,
  output logic signed [COORD_WIDTH:0]         out_dz,
  output vtyp_pkg::flags_t                    out_flags
);
  import vtyp_pkg::*;

  localparam int DXW = COORD_WIDTH + 1;
  localparam int DW  = COORD_WIDTH + GUARD_BITS;

  // Stage one: differences.
  logic                  s1_valid_r;
  logic signed [DXW-1:0] dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DXW'(to_x) - DXW'(from_x);
      dy_r <= DXW'(to_y) - DXW'(from_y);
      dz_r <= DXW'(to_z) - DXW'(from_z);
    end
  end

  // Stage two: pre-rotation into the right half plane.
  logic                      s2_valid_r;
  logic signed [DW-1:0]      x_r, x_nxt;
  logic signed [DW-1:0]      y_r, y_nxt;
  logic signed [ANGLE_W-1:0] z_r, z_nxt;
  logic signed [DXW-1:0]     dz2_r;
  flags_t                    flags_r, flags_nxt;
  logic signed [DW-1:0]      dxw, dyw;
  logic                      dx_zero, dy_zero, dz_zero, dx_pos;

  always_comb begin
    dxw     = DW'(dx_r);
    dyw     = DW'(dy_r);
    dx_zero = (dx_r == '0);
    dy_zero = (dy_r == '0);
    dz_zero = (dz_r == '0);
    dx_pos  = !dx_r[DXW-1] && !dx_zero;

    // The vector handed to CORDIC is (-dx, -dy); when -dx is negative it
    // is turned by a quarter turn toward the positive x axis first.
    if (dx_pos) begin
      if (dy_r[DXW-1] || dy_zero) begin
        x_nxt = (-dyw) <<< FRAC_BITS;
        y_nxt = dxw <<< FRAC_BITS;
        z_nxt = ANGLE_W'(DEG90_ACC);
      end else begin
        x_nxt = dyw <<< FRAC_BITS;
        y_nxt = (-dxw) <<< FRAC_BITS;
        z_nxt = ANGLE_W'(-DEG90_ACC);
      end
    end else begin
      x_nxt = (-dxw) <<< FRAC_BITS;
      y_nxt = (-dyw) <<< FRAC_BITS;
      z_nxt = '0;
    end

    flags_nxt.degen = 1'b0;
    if (dx_zero && dy_zero) begin
      flags_nxt.ykind = YK_ZERO;
      if (dz_zero) begin
        flags_nxt.pkind = PK_ZERO;
        flags_nxt.degen = 1'b1;
      end else if (dz_r[DXW-1]) begin
        flags_nxt.pkind = PK_NEG_90;
      end else begin
        flags_nxt.pkind = PK_POS_90;
      end
    end else begin
      if (dy_zero) begin
        flags_nxt.ykind = dx_r[DXW-1] ? YK_ZERO : YK_NEG_LIMIT;
      end else if (dx_zero) begin
        flags_nxt.ykind = dy_r[DXW-1] ? YK_POS_90 : YK_NEG_90;
      end else begin
        flags_nxt.ykind = YK_CORDIC;
      end
      flags_nxt.pkind = dz_zero ? PK_ZERO : PK_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      dz2_r   <= dz_r;
      flags_r <= flags_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_dz    = dz2_r;
  assign out_flags = flags_r;

endmodule

@@ dv/vector_to_yaw_pitch_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch_core_tb
// Self-checking bench for the yaw/pitch core.
// ----------------------------------------------------------------------------
// Pairs of points go into a queue. A clocked driver moves them over the input
// stream, and an independent bit-true CORDIC model computes the expected
// angles for every accepted transfer. A clocked monitor compares each output
// transfer, field by field, against the oldest expected result. Both stream
// sides throttle at random in three phases. The first phase has a slow
// consumer, the second a slow producer, and the third runs at full rate.
// ----------------------------------------------------------------------------
module vector_to_yaw_pitch_core_tb;

  import vtyp_pkg::*;

  localparam int COORD_W   = COORD_WIDTH_DEF;
  localparam int STAGES    = CORDIC_STAGES_DEF;
  localparam int IN_W      = ((6*COORD_W+7)/8)*8;
  localparam int LATENCY   = 2*STAGES + 5;
  localparam int N_RANDOM  = 500;
  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct {
    logic signed [COORD_W-1:0] from_x, from_y, from_z;
    logic signed [COORD_W-1:0] to_x, to_y, to_z;
  } point_pair_t;

  typedef struct {
    logic signed [YAW_W-1:0]   yaw;
    logic signed [PITCH_W-1:0] pitch;
    logic                      degenerate;
  } bearing_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  point_pair_t pair_q[$];
  bearing_t    bearing_q[$];
  point_pair_t driven_pair;
  int          n_total = 0;
  int          n_sent = 0;
  int          mismatch_cnt = 0;

  vector_to_yaw_pitch_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Vectoring CORDIC. It drives vy toward zero, leaves the scaled magnitude
  // in vx and returns the accumulated angle in 1/32768 degree. Every shift
  // is arithmetic, so negative values round toward minus infinity.
  function automatic longint cordic_angle(inout longint vx, inout longint vy,
                                          input longint acc);
    longint xs;
    longint ys;
    for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx  = vx + ys;
        vy  = vy - xs;
        acc = acc + longint'(ATAN_TAB[i]);
      end else begin
        vx  = vx - ys;
        vy  = vy + xs;
        acc = acc - longint'(ATAN_TAB[i]);
      end
    end
    return acc;
  endfunction

  // Converts to 1/128 degree, rounding half up, and saturates at +/-lim.
  function automatic longint round_limit(longint acc, longint lim);
    longint r;
    r = (acc + 128) >>> 8;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  function automatic bearing_t predict_bearing(point_pair_t p);
    longint   dx, dy, dz;
    longint   vx, vy, acc, t, px, py;
    bearing_t r;
    dx = longint'(p.to_x) - longint'(p.from_x);
    dy = longint'(p.to_y) - longint'(p.from_y);
    dz = longint'(p.to_z) - longint'(p.from_z);
    r.yaw        = '0;
    r.pitch      = '0;
    r.degenerate = 1'b0;
    if (dx == 0 && dy == 0) begin
      // Straight up, straight down, or both points in the same place.
      if (dz > 0) begin
        r.pitch = PITCH_W'(QUARTER_TURN);
      end else if (dz < 0) begin
        r.pitch = PITCH_W'(-QUARTER_TURN);
      end else begin
        r.degenerate = 1'b1;
      end
    end else begin
      // Heading is atan2(-dy, -dx). A vector in the left half-plane is first
      // turned by a quarter turn so the CORDIC sees a non-negative x.
      vx  = -dx * FRAC_ONE;
      vy  = -dy * FRAC_ONE;
      acc = 0;
      if (vx < 0) begin
        t = vx;
        if (vy >= 0) begin
          vx  = vy;
          vy  = -t;
          acc = DEG90_ACC;
        end else begin
          vx  = -vy;
          vy  = t;
          acc = -DEG90_ACC;
        end
      end
      acc = cordic_angle(vx, vy, acc);
      if (dy == 0) begin
        r.yaw = (dx < 0) ? '0 : YAW_W'(-YAW_LIMIT);
      end else if (dx == 0) begin
        r.yaw = (dy > 0) ? YAW_W'(-QUARTER_TURN) : YAW_W'(QUARTER_TURN);
      end else begin
        r.yaw = YAW_W'(round_limit(acc, YAW_LIMIT));
      end
      // The elevation pass reuses the gained magnitude, so dz gets the same
      // gain before it goes in.
      if (dz != 0) begin
        px = vx;
        py = dz * GAIN_Q16;
        r.pitch = PITCH_W'(round_limit(cordic_angle(px, py, 0), QUARTER_TURN));
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic add_pair(logic signed [COORD_W-1:0] fx, logic signed [COORD_W-1:0] fy,
                          logic signed [COORD_W-1:0] fz, logic signed [COORD_W-1:0] tx,
                          logic signed [COORD_W-1:0] ty, logic signed [COORD_W-1:0] tz);
    point_pair_t p;
    p.from_x = fx;
    p.from_y = fy;
    p.from_z = fz;
    p.to_x   = tx;
    p.to_y   = ty;
    p.to_z   = tz;
    pair_q.push_back(p);
  endtask

  // The throttle phase follows the number of input transfers. In the first
  // third the consumer is slow. In the second the producer is slow. In the
  // last third neither side stalls.
  function automatic int sender_idle_pct();
    if (n_sent < n_total / 3) begin
      return 22;
    end else if (n_sent < (2 * n_total) / 3) begin
      return 77;
    end
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (n_sent < n_total / 3) begin
      return 77;
    end else if (n_sent < (2 * n_total) / 3) begin
      return 22;
    end
    return 0;
  endfunction

  initial begin
    logic signed [COORD_W-1:0] fx, fy, fz, tx, ty, tz;
    int                        sel;

    // Directed cases first.
    add_pair(0, 0, 0, 0, 0, 0);                          // both points at origin
    add_pair(C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX);  // coincident at extremes
    add_pair(-1, -1, -1, -1, -1, -1);                    // coincident, all bits set
    add_pair(100, -200, 0, 100, -200, C_MAX);            // straight up
    add_pair(100, -200, C_MAX, 100, -200, C_MIN);        // straight down, widest dz
    add_pair(0, 0, 5, 7, 9, 5);                          // level
    add_pair(0, 0, 0, -5, 0, 3);                         // along -x: yaw zero
    add_pair(0, 0, 0, 5, 0, -3);                         // along +x: held at -180
    add_pair(C_MIN, 0, 0, C_MAX, 0, 0);                  // widest dx on the x axis
    add_pair(0, 0, 0, 0, 8, 0);                          // along +y
    add_pair(0, 0, 0, 0, -8, 1);                         // along -y
    add_pair(C_MIN, 0, 0, C_MAX, -1, 0);                 // just short of +180
    add_pair(C_MIN, 0, 0, C_MAX, 1, 0);                  // just short of -180
    add_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);  // widest positive span
    add_pair(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);  // widest negative span
    add_pair(0, 0, C_MIN, 1, 0, C_MAX);                  // nearly vertical, up
    add_pair(0, 0, C_MAX, 0, -1, C_MIN);                 // nearly vertical, down
    add_pair(0, 0, 0, 3, 4, 10);                         // one vector per quadrant
    add_pair(0, 0, 0, -3, 4, -10);
    add_pair(0, 0, 0, 3, -4, 0);
    add_pair(0, 0, 0, -3, -4, 7);

    // Random part. Most items use full-range coordinates. The rest are short
    // vectors, vectors with a zero component, vertical vectors and equal points.
    for (int n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(99, 0);
      fx = COORD_W'($urandom);
      fy = COORD_W'($urandom);
      fz = COORD_W'($urandom);
      tx = COORD_W'($urandom);
      ty = COORD_W'($urandom);
      tz = COORD_W'($urandom);
      if (sel < 25) begin
        tx = COORD_W'(fx + ($urandom_range(512, 0) - 256));
        ty = COORD_W'(fy + ($urandom_range(512, 0) - 256));
        tz = COORD_W'(fz + ($urandom_range(64, 0) - 32));
      end else if (sel < 40) begin
        case ($urandom_range(2, 0))
          0: begin
            tx = fx;
          end
          1: begin
            ty = fy;
          end
          default: begin
            tz = fz;
          end
        endcase
      end else if (sel < 48) begin
        tx = fx;
        ty = fy;
        if ($urandom_range(1, 0) == 1) begin
          tz = fz;
        end
      end
      add_pair(fx, fy, fz, tx, ty, tz);
    end
    n_total = pair_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent < n_total || bearing_q.size() != 0) begin
      @(posedge clk);
    end
    // Give any unexpected late output time to appear.
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  // When the held item is taken at this edge, its expected result is queued.
  // After that the next item goes out, or the bus idles. The valid only
  // changes when the bus is free, so a held item never drops.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        bearing_q.push_back(predict_bearing(driven_pair));
        n_sent <= n_sent + 1;
      end
      if (pair_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct()) begin
        driven_pair = pair_q.pop_front();
        in_tdata  <= IN_W'({driven_pair.to_z, driven_pair.to_y, driven_pair.to_x,
                            driven_pair.from_z, driven_pair.from_y, driven_pair.from_x});
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------

  // Every mismatch prints one line and is counted.
  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    bearing_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (bearing_q.size() == 0) begin
          report_mismatch("unexpected transfer, yaw", $signed(out_tdata[YAW_W-1:0]), 0);
        end else begin
          want = bearing_q.pop_front();
          if ($signed(out_tdata[YAW_W-1:0]) != want.yaw) begin
            report_mismatch("yaw", $signed(out_tdata[YAW_W-1:0]), want.yaw);
          end
          if ($signed(out_tdata[YAW_W+PITCH_W-1:YAW_W]) != want.pitch) begin
            report_mismatch("pitch", $signed(out_tdata[YAW_W+PITCH_W-1:YAW_W]), want.pitch);
          end
          if (out_tuser !== want.degenerate) begin
            report_mismatch("degenerate", out_tuser, want.degenerate);
          end
        end
      end
      out_tready <= ($urandom_range(99, 0) >= receiver_stall_pct());
    end
  end

endmodule
